// ----- hdl/spm_pkg.sv -----
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants
// Segment table entry, result record, sequencer states and unit opcodes
// for the segment page permission merger.
// ----------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

    localparam int ADDR_W      = 64;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_W      = ADDR_W - PAGE_SHIFT;
    localparam int RIGHTS_W    = 3;
    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 136;

    localparam logic [ADDR_W-1:0] PAGE_ROUND = 64'h0000_0000_0000_0FFF;

    // Input operation, carried in the slave tuser
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_BIAS,
        S_ADD_SIZE,
        S_ADD_ROUND,
        S_Q_START,
        S_Q_SCAN,
        S_Q_MERGE,
        S_OUT
    } state_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_WIN = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [ADDR_W-1:0] sum;
        logic              carry;
        logic              hit;
    } alu_res_t;

    typedef struct packed {
        logic [PAGE_W-1:0]   start_page;
        logic [PAGE_W-1:0]   end_page;
        logic [RIGHTS_W-1:0] rights;
    } seg_entry_t;

    typedef struct packed {
        logic                table_full;
        logic                covered;
        logic                can_read;
        logic                can_write;
        logic                can_exec;
        logic                run_valid;
        logic [ADDR_W-1:0]   run_begin;
        logic [ADDR_W-1:0]   run_finish;
        logic [RIGHTS_W-1:0] run_perm;
    } res_t;

endpackage

`default_nettype wire

// ----- hdl/spm_alu.sv -----
// ----------------------------------------------------------------------------
// spm_alu: shared add / window-compare unit
// ADD gives a + b with carry out; WIN tests b <= a < c.
// ----------------------------------------------------------------------------
`default_nettype none

module spm_alu
    import spm_pkg::*;
(
    input  alu_op_t           op,
    input  logic [ADDR_W-1:0] a,
    input  logic [ADDR_W-1:0] b,
    input  logic [ADDR_W-1:0] c,
    output alu_res_t          res
);

    logic [ADDR_W:0] sum_full;

    assign sum_full = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        res = '0;
        unique case (op)
            ALU_ADD:
            begin
                res.sum   = sum_full[ADDR_W-1:0];
                res.carry = sum_full[ADDR_W];
            end
            ALU_WIN:
            begin
                res.hit = (a >= b) && (a < c);
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/spm_seg_mem.sv -----
// ----------------------------------------------------------------------------
// spm_seg_mem: segment table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spm_seg_mem
    import spm_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  seg_entry_t    wdata,
    input  logic [AW-1:0] raddr,
    output seg_entry_t    rdata
);

    seg_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/segment_page_permission_merger.sv -----
// ----------------------------------------------------------------------------
// segment_page_permission_merger: segment table with page rights and runs
// Stores relocated loadable segments and answers page queries with merged
// R/W/X rights, coalescing adjacent equal-rights pages into runs.
// ----------------------------------------------------------------------------
// One item is handled at a time; s_axis_tready is high only while the
// sequencer is idle. Clear and flush go straight to the result hand-off. An
// add runs bias add, size add, page round-up with table write and result
// hand-off in that order; an add dropped at the bias or size stage goes
// straight to the hand-off. A page query reads the stored segments from the
// table memory one entry per cycle and puts each entry through the shared
// window compare, then merges the page into the open run before the
// hand-off. The hand-off waits while the output register is still full; the
// sequencer returns to idle on the edge that loads the output register.
// Results land in an output register, so the next item is taken while the
// previous result still waits on m_axis_tready. The bias register is sampled
// when an add starts; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_page_permission_merger
    import spm_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Bias register write
    input  logic                   cfg_we,
    input  logic [ADDR_W-1:0]      cfg_wdata,

    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] seg_is_load, [64:1] seg_vaddr, [128:65] seg_memsize,
    // [131:129] seg_perm, [195:132] page_addr, [199:196] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] op
    input  logic [1:0]             s_axis_tuser,

    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] table_full, [1] covered, [2] can_read, [3] can_write, [4] can_exec,
    // [68:5] run_begin, [132:69] run_finish, [135:133] run_perm
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] run_valid
    output logic                   m_axis_tuser
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic                is_load_reg, is_load_next;
    logic [ADDR_W-1:0]   vaddr_reg, vaddr_next;
    logic [ADDR_W-1:0]   size_reg, size_next;
    logic [RIGHTS_W-1:0] perm_reg, perm_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [ADDR_W-1:0]   bias_reg, bias_next;
    logic [ADDR_W-1:0]   acc_reg, acc_next;
    logic [PAGE_W-1:0]   base_page_reg, base_page_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                hit_reg, hit_next;
    logic [RIGHTS_W-1:0] flags_reg, flags_next;
    logic                run_open_reg, run_open_next;
    logic [PAGE_W-1:0]   run_start_reg, run_start_next;
    // one extra bit: the run past the top page ends at 2^52
    logic [PAGE_W:0]     run_end_reg, run_end_next;
    logic [RIGHTS_W-1:0] run_rights_reg, run_rights_next;
    res_t                res_reg, res_next;
    res_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // Shared unit and table
    // ------------------------------------------------------------------
    alu_op_t           alu_op;
    logic [ADDR_W-1:0] alu_a, alu_b, alu_c;
    alu_res_t          alu_res;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    seg_entry_t        mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    seg_entry_t        mem_rdata;

    spm_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .c   (alu_c),
        .res (alu_res)
    );

    spm_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .AW    (IDX_W)
    ) u_seg_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    logic                s_xfer;
    logic                out_free;
    logic                scan_last;
    logic                table_is_full;
    logic [RIGHTS_W-1:0] q_rights;
    logic                run_extends;
    res_t                emit_res;

    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign scan_last     = ((CNT_W)'(idx_reg) + CNT_W'(1)) == count_reg;
    assign table_is_full = count_reg >= CNT_W'(MAX_SEGMENTS);
    // segment flags are X,W,R from bit 0; run rights are R,W,X from bit 0
    assign q_rights      = {flags_reg[0], flags_reg[1], flags_reg[2]};
    assign run_extends   = run_open_reg && (run_end_reg == {1'b0, page_reg})
                           && (run_rights_reg == q_rights);

    always_comb
    begin
        emit_res            = '0;
        emit_res.run_valid  = 1'b1;
        emit_res.run_begin  = {run_start_reg, {PAGE_SHIFT{1'b0}}};
        emit_res.run_finish = {run_end_reg[PAGE_W-1:0], {PAGE_SHIFT{1'b0}}};
        emit_res.run_perm   = run_rights_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    unique case (op_t'(s_axis_tuser))
                        OP_ADD:   state_next = S_ADD_BIAS;
                        OP_QUERY: state_next = S_Q_START;
                        default:  state_next = S_OUT;
                    endcase
                end
            end
            S_ADD_BIAS:
            begin
                if (!is_load_reg || (size_reg == '0) || alu_res.carry)
                    state_next = S_OUT;
                else
                    state_next = S_ADD_SIZE;
            end
            S_ADD_SIZE:
            begin
                state_next = alu_res.carry ? S_OUT : S_ADD_ROUND;
            end
            S_ADD_ROUND:
            begin
                state_next = S_OUT;
            end
            S_Q_START:
            begin
                state_next = (count_reg == '0) ? S_Q_MERGE : S_Q_SCAN;
            end
            S_Q_SCAN:
            begin
                if (scan_last)
                    state_next = S_Q_MERGE;
            end
            S_Q_MERGE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and unit control
    // ------------------------------------------------------------------
    always_comb
    begin
        is_load_next    = is_load_reg;
        vaddr_next      = vaddr_reg;
        size_next       = size_reg;
        perm_next       = perm_reg;
        page_next       = page_reg;
        bias_next       = cfg_we ? cfg_wdata : bias_reg;
        acc_next        = acc_reg;
        base_page_next  = base_page_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        flags_next      = flags_reg;
        run_open_next   = run_open_reg;
        run_start_next  = run_start_reg;
        run_end_next    = run_end_reg;
        run_rights_next = run_rights_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        alu_op    = ALU_ADD;
        alu_a     = '0;
        alu_b     = '0;
        alu_c     = '0;
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = '0;
        mem_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    is_load_next = s_axis_tdata[0];
                    vaddr_next   = s_axis_tdata[64:1];
                    size_next    = s_axis_tdata[128:65];
                    perm_next    = s_axis_tdata[131:129];
                    page_next    = s_axis_tdata[195:132+PAGE_SHIFT];
                    res_next     = '0;
                    unique case (op_t'(s_axis_tuser))
                        OP_CLEAR:
                        begin
                            count_next    = '0;
                            run_open_next = 1'b0;
                        end
                        OP_FLUSH:
                        begin
                            if (run_open_reg)
                                res_next = emit_res;
                            run_open_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD_BIAS:
            begin
                alu_a          = vaddr_reg;
                alu_b          = bias_reg;
                acc_next       = alu_res.sum;
                base_page_next = alu_res.sum[ADDR_W-1:PAGE_SHIFT];
            end
            S_ADD_SIZE:
            begin
                alu_a    = acc_reg;
                alu_b    = size_reg;
                acc_next = alu_res.sum;
            end
            S_ADD_ROUND:
            begin
                alu_a = acc_reg;
                alu_b = PAGE_ROUND;
                if (!alu_res.carry)
                begin
                    if (table_is_full)
                    begin
                        res_next.table_full = 1'b1;
                    end
                    else
                    begin
                        mem_we               = 1'b1;
                        mem_wdata.start_page = base_page_reg;
                        mem_wdata.end_page   = alu_res.sum[ADDR_W-1:PAGE_SHIFT];
                        mem_wdata.rights     = perm_reg;
                        count_next           = count_reg + CNT_W'(1);
                    end
                end
            end
            S_Q_START:
            begin
                mem_raddr  = '0;
                idx_next   = '0;
                hit_next   = 1'b0;
                flags_next = '0;
            end
            S_Q_SCAN:
            begin
                // rdata holds entry idx_reg; fetch the next one meanwhile
                alu_op    = ALU_WIN;
                alu_a     = {{PAGE_SHIFT{1'b0}}, page_reg};
                alu_b     = {{PAGE_SHIFT{1'b0}}, mem_rdata.start_page};
                alu_c     = {{PAGE_SHIFT{1'b0}}, mem_rdata.end_page};
                mem_raddr = scan_last ? idx_reg : idx_reg + IDX_W'(1);
                if (alu_res.hit)
                begin
                    hit_next   = 1'b1;
                    flags_next = flags_reg | mem_rdata.rights;
                end
                if (!scan_last)
                    idx_next = idx_reg + IDX_W'(1);
            end
            S_Q_MERGE:
            begin
                alu_a = {{PAGE_SHIFT{1'b0}}, page_reg};
                alu_b = ADDR_W'(1);
                if (!hit_reg)
                begin
                    if (run_open_reg)
                        res_next = emit_res;
                    run_open_next = 1'b0;
                end
                else
                begin
                    if (!run_extends)
                    begin
                        if (run_open_reg)
                            res_next = emit_res;
                        run_open_next   = 1'b1;
                        run_start_next  = page_reg;
                        run_rights_next = q_rights;
                    end
                    run_end_next       = alu_res.sum[PAGE_W:0];
                    res_next.covered   = 1'b1;
                    res_next.can_read  = flags_reg[2];
                    res_next.can_write = flags_reg[1];
                    res_next.can_exec  = flags_reg[0];
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bias_reg       <= '0;
            count_reg      <= '0;
            run_open_reg   <= 1'b0;
            run_start_reg  <= '0;
            run_end_reg    <= '0;
            run_rights_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bias_reg       <= bias_next;
            count_reg      <= count_next;
            run_open_reg   <= run_open_next;
            run_start_reg  <= run_start_next;
            run_end_reg    <= run_end_next;
            run_rights_reg <= run_rights_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        is_load_reg   <= is_load_next;
        vaddr_reg     <= vaddr_next;
        size_reg      <= size_next;
        perm_reg      <= perm_next;
        page_reg      <= page_next;
        acc_reg       <= acc_next;
        base_page_reg <= base_page_next;
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        flags_reg     <= flags_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.run_valid;
    assign m_axis_tdata  = {out_reg.run_perm, out_reg.run_finish, out_reg.run_begin,
                            out_reg.can_exec, out_reg.can_write, out_reg.can_read,
                            out_reg.covered, out_reg.table_full};

`ifndef ASSERT_OFF
    // table never holds more entries than it has
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count above table depth");

    // a transfer in starts work, so the input side goes busy
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // an add result never carries query or run fields
    a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (!m_axis_tdata[1] && !m_axis_tuser))
        else $error("table_full mixed with query or run fields");

    // rights are reported only for a covered page
    a_rights_need_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[4:2] == 3'b000))
        else $error("rights on an uncovered page");
`endif

endmodule

`default_nettype wire
